>>> src/crru_pkg.sv
// Shared types, constants and the binomial coefficient table for the
// combination rank/unrank unit. No dependencies.
package crru_pkg;

  localparam int GroupMax = 32;
  localparam int PosW     = $clog2(GroupMax);
  localparam int CntW     = $clog2(GroupMax) + 1;
  localparam int CoefW    = 29;
  localparam int DataW    = 32;
  localparam int CfgW     = 30;
  localparam int CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGroupSize     = 2'd0,
    CfgSelectedCount = 2'd1,
    CfgRankLimit     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OpRank   = 1'b0,
    OpUnrank = 1'b1
  } op_e;

  typedef logic [GroupMax-1:0][CoefW-1:0] coef_row_t;
  typedef coef_row_t [GroupMax-1:0]       coef_tab_t;

  // One item in flight. bits is indexed by the reversed position
  // q = n-1-pos, so pipeline stage q always uses coefficient row C(q, *).
  typedef struct packed {
    op_e                 op;
    logic                bad;
    logic [CntW-1:0]     rem;
    logic [DataW-1:0]    val;
    logic [GroupMax-1:0] bits;
  } crru_item_t;

  function automatic coef_tab_t build_coef();
    coef_tab_t      t;
    logic [CoefW:0] s;
    t = '0;
    for (int a = 0; a < GroupMax; a++) begin
      for (int b = 0; b < GroupMax; b++) begin
        if (b == 0) begin
          t[a][b] = CoefW'(1);
        end else if (a == 0) begin
          t[a][b] = '0;
        end else begin
          s = {1'b0, t[a-1][b-1]} + {1'b0, t[a-1][b]};
          t[a][b] = s[CoefW-1:0];
        end
      end
    end
    return t;
  endfunction

  localparam coef_tab_t Coef = build_coef();

  function automatic logic [GroupMax-1:0] bit_rev(input logic [GroupMax-1:0] x);
    logic [GroupMax-1:0] r;
    for (int i = 0; i < GroupMax; i++) begin
      r[i] = x[GroupMax-1-i];
    end
    return r;
  endfunction

endpackage

>>> src/crru_stage.sv
// One position step of the rank/unrank walk, with its pipeline register.
// Depends on crru_pkg.
module crru_stage import crru_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [PosW-1:0] pos_i,       // reversed position q handled here
  input  logic [CntW-1:0] group_n_i,   // effective n
  input  coef_row_t       coef_row_i,  // C(q, j) for j = 0..GroupMax-1
  input  logic            valid_i,
  input  crru_item_t      item_i,
  output logic            ready_o,
  output logic            valid_o,
  output crru_item_t      item_o,
  input  logic            ready_i
);

  logic             valid_q;
  crru_item_t       item_q, item_d;
  logic             active;
  logic [PosW-1:0]  coef_idx;
  logic [DataW-1:0] coef_ext;
  logic             take;

  assign active   = ({1'b0, pos_i} < group_n_i) && (item_i.rem != '0);
  assign coef_idx = PosW'(item_i.rem - CntW'(1));
  assign coef_ext = {{(DataW-CoefW){1'b0}}, coef_row_i[coef_idx]};
  // rank takes the bit from the mask, unrank places it when the rank fits
  assign take     = (item_i.op == OpUnrank) ? (item_i.val < coef_ext) : item_i.bits[pos_i];

  always_comb begin
    item_d = item_i;
    if (active) begin
      if (take) begin
        item_d.rem          = item_i.rem - CntW'(1);
        item_d.bits[pos_i]  = 1'b1;
      end else if (item_i.op == OpUnrank) begin
        item_d.val = item_i.val - coef_ext;
      end else begin
        item_d.val = item_i.val + coef_ext;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> src/combination_rank_unrank_unit.sv
// Top level of the combination rank/unrank unit: config registers, input
// checks, the chain of position stages and the output register.
// Depends on crru_pkg and crru_stage.
//
// Converts between a k-of-n bit mask and its combinatorial-number-system rank.
// One item is accepted per clock unless the output stalls; each passes an input
// stage (range and popcount checks, mask alignment), 32 position stages that
// each do one coefficient select, one compare and one 32-bit add or subtract,
// and the output register. Stalls on the output side fill bubbles first, so the
// input keeps taking items while a finished result waits. No clearing pass is
// needed after reset. The user must write configuration only while no item is
// in flight; the block itself does not enforce it.
module combination_rank_unrank_unit import crru_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // [31:0] mask_in, [63:32] rank_in
  input  logic               s_axis_tuser,   // [0] operation
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DataW-1:0]   m_axis_tdata,   // [31:0] value_out
  output logic               m_axis_tuser    // [0] valid_res
);

  logic [CntW-1:0] group_size_q;
  logic [CntW-1:0] selected_count_q;
  logic [CfgW-1:0] rank_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q     <= CntW'(24);
      selected_count_q <= CntW'(12);
      rank_limit_q     <= CfgW'(2704156);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgGroupSize:     group_size_q     <= cfg_data_i[CntW-1:0];
        CfgSelectedCount: selected_count_q <= cfg_data_i[CntW-1:0];
        CfgRankLimit:     rank_limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] shift_amt;
  assign n_eff     = (group_size_q > CntW'(GroupMax)) ? CntW'(GroupMax) : group_size_q;
  assign shift_amt = CntW'(GroupMax) - n_eff;

  // input stage
  logic [DataW-1:0] mask_in, rank_in;
  logic [CntW-1:0]  pop;
  logic             bad_in;
  crru_item_t       in_item;

  assign mask_in = s_axis_tdata[31:0];
  assign rank_in = s_axis_tdata[63:32];
  assign pop     = CntW'($countones(mask_in));

  always_comb begin
    in_item.op  = op_e'(s_axis_tuser);
    bad_in      = selected_count_q > n_eff;
    if (in_item.op == OpUnrank) begin
      bad_in       = bad_in || (rank_in >= {{(DataW-CfgW){1'b0}}, rank_limit_q});
      in_item.val  = rank_in;
      in_item.bits = '0;
    end else begin
      bad_in       = bad_in || (pop != selected_count_q);
      in_item.val  = '0;
      // bit q of the aligned mask is position n-1-q
      in_item.bits = bit_rev(mask_in << shift_amt);
    end
    in_item.bad = bad_in;
    in_item.rem = selected_count_q;
  end

  crru_item_t pipe     [GroupMax+1];
  logic       pipe_v   [GroupMax+1];
  logic       pipe_rdy [GroupMax+1];  // consumer of pipe[i] can take a transfer

  logic ready0;
  logic pipe0_v_q;
  crru_item_t pipe0_q;

  assign ready0        = !pipe0_v_q || pipe_rdy[0];
  assign s_axis_tready = ready0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe0_v_q <= 1'b0;
    end else if (ready0) begin
      pipe0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready0 && s_axis_tvalid) begin
      pipe0_q <= in_item;
    end
  end

  assign pipe[0]   = pipe0_q;
  assign pipe_v[0] = pipe0_v_q;

  // stage i handles reversed position q = GroupMax-1-i, highest q first
  for (genvar i = 0; i < GroupMax; i++) begin : g_stage
    crru_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pos_i      (PosW'(GroupMax - 1 - i)),
      .group_n_i  (n_eff),
      .coef_row_i (Coef[GroupMax-1-i]),
      .valid_i    (pipe_v[i]),
      .item_i     (pipe[i]),
      .ready_o    (pipe_rdy[i]),
      .valid_o    (pipe_v[i+1]),
      .item_o     (pipe[i+1]),
      .ready_i    (pipe_rdy[i+1])
    );
  end

  // output register
  logic             out_v_q;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic             out_ok_q, out_ok_d;
  crru_item_t       last;

  assign last               = pipe[GroupMax];
  assign pipe_rdy[GroupMax] = !out_v_q || m_axis_tready;

  always_comb begin
    out_ok_d = !last.bad && (last.rem == '0);
    if (!out_ok_d) begin
      out_data_d = '0;
    end else if (last.op == OpUnrank) begin
      out_data_d = bit_rev(last.bits) >> shift_amt;
    end else begin
      out_data_d = last.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pipe_rdy[GroupMax]) begin
      out_v_q <= pipe_v[GroupMax];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_rdy[GroupMax] && pipe_v[GroupMax]) begin
      out_data_q <= out_data_d;
      out_ok_q   <= out_ok_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result carries a nonzero value");

  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_v[GroupMax] && !last.bad |-> last.rem <= selected_count_q)
    else $error("remaining selection count out of range at last stage");

  a_empty_entry_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe0_v_q |-> s_axis_tready)
    else $error("input stalled with empty entry stage");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && pipe_v[GroupMax] |=> m_axis_tvalid)
    else $error("finished item not moved to the output register");

endmodule

>>> test/tb_combination_rank_unrank_unit.sv
// Self-checking testbench for combination_rank_unrank_unit: directed table, then random
// phases under random configurations, checked against a binomial-table predictor.
// Depends on crru_pkg and the unit RTL.
module tb_combination_rank_unrank_unit;
  import crru_pkg::*;

  localparam int Latency    = 34;
  localparam int StallLimit = 2000;
  localparam int NumPhases  = 12;
  localparam int PhaseItems = 75;
  localparam int NumRows    = 26;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             ok;
  } conv_res_t;

  typedef struct packed {
    logic [5:0]       gsz;
    logic [5:0]       kcnt;
    logic [CfgW-1:0]  lim;
    op_e              op;
    logic [31:0]      mask;
    logic [31:0]      rank;
    bit               typed;
    logic [DataW-1:0] exp_val;
    bit               exp_ok;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgGroupSize;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata = '0;   // [31:0] mask_in, [63:32] rank_in
  logic               s_axis_tuser = 1'b0; // [0] operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DataW-1:0]   m_axis_tdata;        // [31:0] value_out
  logic               m_axis_tuser;        // [0] valid_res

  combination_rank_unrank_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // current register contents, mirrored at each write
  logic [5:0]      cur_gsz  = 6'd24;
  logic [5:0]      cur_kcnt = 6'd12;
  logic [CfgW-1:0] cur_lim  = CfgW'(2704156);

  longint unsigned choose_tab [0:32][0:32];
  conv_res_t       pending_results [$];

  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int snk_gap = 0;
  int errors = 0;
  int n_rank = 0, n_unrank = 0, n_ok = 0, n_bad = 0, n_cfg = 0;
  int idle_cycles = 0;

  dir_row_t dir_rows [NumRows] = '{
    // reset configuration: n=24, k=12
    '{6'd24, 6'd12, 30'd2704156, OpRank,   32'h0000_0FFF, 32'h0,          1, 32'h0,   1},
    '{6'd24, 6'd12, 30'd2704156, OpRank,   32'h0,         32'h0,          1, 32'h0,   0},
    '{6'd24, 6'd12, 30'd2704156, OpRank,   32'hFFFF_FFFF, 32'hDEAD_BEEF,  1, 32'h0,   0},
    '{6'd24, 6'd12, 30'd2704156, OpRank,   32'hFFF0_0000, 32'h0,          1, 32'h0,   0},
    '{6'd24, 6'd12, 30'd2704156, OpUnrank, 32'hA5A5_A5A5, 32'd0,          1, 32'hFFF, 1},
    '{6'd24, 6'd12, 30'd2704156, OpUnrank, 32'h0,         32'd2704155,    0, 32'h0,   0},
    '{6'd24, 6'd12, 30'd2704156, OpUnrank, 32'h0,         32'd2704156,    1, 32'h0,   0},
    '{6'd24, 6'd12, 30'd2704156, OpUnrank, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 32'h0,   0},
    // 3-of-8: the first set, the last set, and a rank below the limit but past the last set
    '{6'd8,  6'd3,  30'd1000,    OpUnrank, 32'h0,         32'd0,          1, 32'h7,   1},
    '{6'd8,  6'd3,  30'd1000,    OpUnrank, 32'h0,         32'd55,         0, 32'h0,   0},
    '{6'd8,  6'd3,  30'd1000,    OpUnrank, 32'h0,         32'd56,         1, 32'h0,   0},
    // k above n
    '{6'd8,  6'd9,  30'd1000,    OpRank,   32'h0000_01FF, 32'h0,          1, 32'h0,   0},
    '{6'd8,  6'd9,  30'd1000,    OpUnrank, 32'h0,         32'd0,          1, 32'h0,   0},
    // empty group, then the full group of 32
    '{6'd0,  6'd0,  30'd5,       OpRank,   32'h0,         32'h0,          1, 32'h0,   1},
    '{6'd0,  6'd0,  30'd5,       OpUnrank, 32'h0,         32'd4,          1, 32'h0,   1},
    '{6'd0,  6'd0,  30'd5,       OpUnrank, 32'h0,         32'd5,          1, 32'h0,   0},
    '{6'd32, 6'd32, 30'd1,       OpRank,   32'hFFFF_FFFF, 32'h0,          1, 32'h0,   1},
    '{6'd32, 6'd32, 30'd1,       OpUnrank, 32'h0,         32'd0,          1, 32'hFFFF_FFFF, 1},
    '{6'd32, 6'd16, 30'h3FFF_FFFF, OpUnrank, 32'h0,       32'd601080389,  0, 32'h0,   0},
    '{6'd32, 6'd16, 30'h3FFF_FFFF, OpUnrank, 32'h0,       32'd601080390,  1, 32'h0,   0},
    '{6'd32, 6'd16, 30'h3FFF_FFFF, OpRank,   32'h0000_FFFF, 32'h0,        1, 32'h0,   1},
    // n above the maximum saturates; then a zero rank limit, n and k above the maximum, and n=1
    '{6'd40, 6'd16, 30'd601080390, OpUnrank, 32'h0,       32'd0,          1, 32'hFFFF, 1},
    '{6'd40, 6'd16, 30'd601080390, OpUnrank, 32'h0,       32'd601080390,  1, 32'h0,   0},
    '{6'd8,  6'd0,  30'd0,       OpUnrank, 32'h0,         32'd0,          1, 32'h0,   0},
    '{6'd63, 6'd63, 30'h3FFF_FFFF, OpRank, 32'hFFFF_FFFF, 32'h0,          1, 32'h0,   0},
    '{6'd1,  6'd1,  30'd1,       OpUnrank, 32'h0,         32'd0,          1, 32'h1,   1}
  };

  function automatic longint unsigned count_sets(int n, int k);
    if (k > n || n > 32) return 0;
    return choose_tab[n][k];
  endfunction

  function automatic conv_res_t expected_conversion(op_e op, logic [31:0] mask,
                                                    logic [31:0] rank);
    int              n;
    int              rem;
    longint unsigned acc;
    longint unsigned r;
    longint unsigned c;
    logic [31:0]     bits;
    conv_res_t       res;
    n = (cur_gsz > 6'd32) ? 32 : int'(cur_gsz);
    rem = int'(cur_kcnt);
    res = '0;
    if (rem > n) return res;
    if (op == OpRank) begin
      if ($countones(mask) != rem) return res;
      acc = 0;
      for (int p = 0; p < n; p++) begin
        if (mask[p]) rem--;
        else if (rem > 0) acc += choose_tab[n-p-1][rem-1];
      end
      if (rem != 0) return res;
      res.value = acc[31:0];
    end else begin
      if (32'(rank) >= 32'(cur_lim)) return res;
      r = rank;
      bits = '0;
      for (int p = 0; p < n && rem > 0; p++) begin
        c = choose_tab[n-p-1][rem-1];
        if (r < c) begin
          bits[p] = 1'b1;
          rem--;
        end else begin
          r -= c;
        end
      end
      if (rem != 0) return res;
      res.value = bits;
    end
    res.ok = 1'b1;
    return res;
  endfunction

  // random k-of-n mask by selection sampling
  function automatic logic [31:0] random_selection(int n, int k);
    logic [31:0] m;
    int          need;
    m = '0;
    need = k;
    for (int p = 0; p < n; p++) begin
      if (need > 0 && $urandom_range(0, n - p - 1) < need) begin
        m[p] = 1'b1;
        need--;
      end
    end
    return m;
  endfunction

  // caller is at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(op_e op, logic [31:0] mask, logic [31:0] rank, conv_res_t exp);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {rank, mask};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(exp);
    if (op == OpRank) n_rank++;
    else n_unrank++;
    @(negedge clk_i);
  endtask

  // drain the pipe, then write all three registers
  task automatic apply_config(logic [5:0] gsz, logic [5:0] kcnt, logic [CfgW-1:0] lim);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= CfgGroupSize; cfg_data_i <= CfgW'(gsz);
    @(negedge clk_i);
    cfg_idx_i <= CfgSelectedCount; cfg_data_i <= CfgW'(kcnt);
    @(negedge clk_i);
    cfg_idx_i <= CfgRankLimit; cfg_data_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_gsz = gsz;
    cur_kcnt = kcnt;
    cur_lim = lim;
    n_cfg++;
  endtask

  task automatic random_phase(int num_items, bit full_group);
    int              n, k, eff;
    longint unsigned sets;
    longint unsigned span;
    logic [CfgW-1:0] lim;
    logic [31:0]     mask, rank;
    op_e             op;
    if (full_group) n = 32;
    else if ($urandom_range(0, 9) != 0) n = $urandom_range(1, 32);
    else n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
    eff = (n > 32) ? 32 : n;
    k = ($urandom_range(0, 9) != 0) ? $urandom_range(0, eff) : $urandom_range(0, 63);
    sets = count_sets(eff, k);
    case ($urandom_range(0, 5))
      0:       lim = CfgW'($urandom);
      1:       lim = '1;
      2:       lim = (sets > 2) ? CfgW'(sets - longint'($urandom_range(0, 2))) : CfgW'(sets);
      default: lim = CfgW'(sets);
    endcase
    apply_config(6'(n), 6'(k), lim);
    span = (longint'(lim) < sets) ? longint'(lim) : sets;
    for (int i = 0; i < num_items; i++) begin
      op = op_e'($urandom_range(0, 1));
      mask = $urandom;
      rank = $urandom;
      if (op == OpRank) begin
        case ($urandom_range(0, 9))
          0:       ;  // noise
          1:       mask = random_selection(eff, k) | (32'h1 << $urandom_range(eff, 31));
          default: if (k <= eff) mask = random_selection(eff, k);
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0:       ;  // noise
          1:       rank = 32'(lim) - $urandom_range(0, 1);
          2:       rank = 32'(sets);
          default: if (span > 0) rank = $urandom_range(0, 32'(span - 1));
        endcase
      end
      send_item(op, mask, rank, expected_conversion(op, mask, rank));
    end
  endtask

  // result sink with random stall bursts
  always @(negedge clk_i) begin
    if (!snk_idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    conv_res_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value_out=%h valid_res=%b", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (m_axis_tdata !== exp.value) begin
          $display("%0t: value_out mismatch: expected %h actual %h", $time,
                   exp.value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== exp.ok) begin
          $display("%0t: valid_res mismatch: expected %b actual %b", $time,
                   exp.ok, m_axis_tuser);
          errors++;
        end
        if (exp.ok) n_ok++;
        else n_bad++;
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, pending_results.size());
      $display("tb_combination_rank_unrank_unit failed");
      $finish;
    end
  end

  initial begin
    conv_res_t exp;
    for (int a = 0; a <= 32; a++) begin
      for (int b = 0; b <= 32; b++) begin
        if (b == 0) choose_tab[a][b] = 1;
        else if (a == 0) choose_tab[a][b] = 0;
        else choose_tab[a][b] = choose_tab[a-1][b-1] + choose_tab[a-1][b];
      end
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // first rows run on the reset values of the registers
    foreach (dir_rows[i]) begin
      if (dir_rows[i].gsz != cur_gsz || dir_rows[i].kcnt != cur_kcnt ||
          dir_rows[i].lim != cur_lim)
        apply_config(dir_rows[i].gsz, dir_rows[i].kcnt, dir_rows[i].lim);
      if (dir_rows[i].typed) begin
        exp.value = dir_rows[i].exp_val;
        exp.ok = dir_rows[i].exp_ok;
      end else begin
        exp = expected_conversion(dir_rows[i].op, dir_rows[i].mask, dir_rows[i].rank);
      end
      send_item(dir_rows[i].op, dir_rows[i].mask, dir_rows[i].rank, exp);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end
      random_phase(PhaseItems, ph == 0 || ph == NumPhases - 1);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    $display("Covered %0d rank and %0d unrank transfers over %0d register settings,",
             n_rank, n_unrank, n_cfg + 1);
    $display("giving %0d valid and %0d invalid results.", n_ok, n_bad);
    if (errors == 0) begin
      $display("tb_combination_rank_unrank_unit passed");
    end else begin
      $display("tb_combination_rank_unrank_unit failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/crru_pkg.sv
src/crru_stage.sv
src/combination_rank_unrank_unit.sv
test/tb_combination_rank_unrank_unit.sv
